/* rtl/core/psq_pkg.sv */
// Shared types and constants for the priority semaphore queue.
// Depends on nothing; every other file imports it.
package psq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;
  localparam int PRIO_BITS   = 8;
  localparam int CFG_W       = 10;
  localparam int CNT_W       = 12;
  localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int STATUS_W    = 3;

  localparam logic [CNT_W-1:0] SEM_MAX = {1'b0, {(CNT_W-1){1'b1}}};

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED = 3'd0,
    ST_QUEUED  = 3'd1,
    ST_FULL    = 3'd2,
    ST_WOKE    = 3'd3,
    ST_NOWAIT  = 3'd4,
    ST_SAT     = 3'd5
  } status_t;

  typedef enum logic {
    ACT_WAIT   = 1'b0,
    ACT_SIGNAL = 1'b1
  } action_t;

  typedef struct packed {
    logic                 action;
    logic [ID_BITS-1:0]   waiter_id;
    logic [PRIO_BITS-1:0] priority_req;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [ID_BITS-1:0]   woken_id;
    logic [PRIO_BITS-1:0] woken_priority;
    logic [LEVEL_W-1:0]   queue_level;
  } rsp_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the request
    logic exec;    // perform the captured request
    logic cfg_wr;  // write the initial count register
  } cmd_t;

endpackage

/* rtl/core/psq_ctrl.sv */
// Controller state machine: request acceptance, execute step and result strobe.
// Depends on psq_pkg.
module psq_ctrl import psq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic cfg_valid,
  output logic busy,
  output logic cfg_ready,
  output logic out_valid,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    busy          = 1'b0;
    cfg_ready     = 1'b0;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        cfg_ready  = 1'b1;
        cmd.cfg_wr = cfg_valid;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        busy          = 1'b1;
        cmd.exec      = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/core/psq_datapath.sv */
// Datapath: semaphore count, sorted shifting wait queue and result register.
// Depends on psq_pkg.
module psq_datapath import psq_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  input  req_t             in_req,
  input  logic [CFG_W-1:0] cfg_data,
  output rsp_t             out_rsp
);

  logic [CNT_W-1:0]     sem_r, sem_nxt;
  logic [LEVEL_W-1:0]   level_r, level_nxt;
  req_t                 req_r;
  rsp_t                 rsp_r, rsp_nxt;

  // Queue cells, entry 0 is the head; each cell sees only its neighbors.
  logic [ID_BITS-1:0]   ids_r   [QUEUE_DEPTH];
  logic [PRIO_BITS-1:0] prios_r [QUEUE_DEPTH];
  logic [ID_BITS-1:0]   ids_nxt   [QUEUE_DEPTH];
  logic [PRIO_BITS-1:0] prios_nxt [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] ge;

  logic sem_pos, sem_neg, sem_sat, q_full, q_nonempty;
  logic do_insert, do_remove;

  assign sem_neg    = sem_r[CNT_W-1];
  assign sem_pos    = !sem_neg && (sem_r != '0);
  assign sem_sat    = (sem_r == SEM_MAX);
  assign q_full     = (level_r == LEVEL_W'(QUEUE_DEPTH));
  assign q_nonempty = (level_r != '0);

  // Occupied cells whose priority is at least the newcomer's; a prefix.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ge[i] = (LEVEL_W'(i) < level_r) && (prios_r[i] >= req_r.priority_req);
    end
  end

  always_comb begin
    sem_nxt   = sem_r;
    level_nxt = level_r;
    do_insert = 1'b0;
    do_remove = 1'b0;
    rsp_nxt   = rsp_r;
    if (cmd.exec) begin
      rsp_nxt.woken_id       = '0;
      rsp_nxt.woken_priority = '0;
      if (req_r.action == ACT_WAIT) begin
        if (sem_pos) begin
          sem_nxt        = sem_r - CNT_W'(1);
          rsp_nxt.status = ST_GRANTED;
        end else if (q_full) begin
          rsp_nxt.status = ST_FULL;
        end else begin
          sem_nxt        = sem_r - CNT_W'(1);
          level_nxt      = level_r + LEVEL_W'(1);
          do_insert      = 1'b1;
          rsp_nxt.status = ST_QUEUED;
        end
      end else begin
        if (sem_sat) begin
          rsp_nxt.status = ST_SAT;
        end else begin
          sem_nxt = sem_r + CNT_W'(1);
          if (sem_neg && q_nonempty) begin
            level_nxt              = level_r - LEVEL_W'(1);
            do_remove              = 1'b1;
            rsp_nxt.status         = ST_WOKE;
            rsp_nxt.woken_id       = ids_r[0];
            rsp_nxt.woken_priority = prios_r[0];
          end else begin
            rsp_nxt.status = ST_NOWAIT;
          end
        end
      end
      rsp_nxt.queue_level = level_nxt;
    end else if (cmd.cfg_wr && !q_nonempty) begin
      // Reload the count only while nobody is waiting.
      sem_nxt = CNT_W'(cfg_data);
    end
  end

  // Per-cell update: keep, take the newcomer, or shift from a neighbor.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ids_nxt[i]   = ids_r[i];
      prios_nxt[i] = prios_r[i];
      if (do_insert && !ge[i]) begin
        if (i == 0 || ge[(i == 0) ? 0 : i-1]) begin
          ids_nxt[i]   = req_r.waiter_id;
          prios_nxt[i] = req_r.priority_req;
        end else begin
          ids_nxt[i]   = ids_r[(i == 0) ? 0 : i-1];
          prios_nxt[i] = prios_r[(i == 0) ? 0 : i-1];
        end
      end else if (do_remove && i < QUEUE_DEPTH-1) begin
        ids_nxt[i]   = ids_r[(i < QUEUE_DEPTH-1) ? i+1 : i];
        prios_nxt[i] = prios_r[(i < QUEUE_DEPTH-1) ? i+1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sem_r   <= '0;
      level_r <= '0;
    end else begin
      sem_r   <= sem_nxt;
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req;
    end
    rsp_r <= rsp_nxt;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ids_r[i]   <= ids_nxt[i];
      prios_r[i] <= prios_nxt[i];
    end
  end

  assign out_rsp = rsp_r;

endmodule

/* rtl/core/priority_semaphore_queue_top.sv */
// Top level of the priority semaphore queue: controller plus datapath.
// Depends on psq_pkg, psq_ctrl and psq_datapath.
//
// Counting semaphore with a priority-ordered wait queue of QUEUE_DEPTH entries.
// Issue a request by raising start while busy is low; action 0 is a wait,
// action 1 a signal. Every request yields exactly one result, shown on out_rsp
// for a single cycle with out_valid high, ending at the clock edge that closes
// that cycle; the receiver cannot stall it, so capture it on that edge. A
// request is first captured, then executed in a step in which the shifting
// sorted queue inserts or removes a waiter and the count moves. busy is high
// only in the execute step, so a new request is not taken while one executes,
// but can be accepted in the same cycle as the previous result strobe. Waiters
// of equal priority are served first come, first served. A wait on a full
// queue is rejected without touching the count; a signal at the largest count
// saturates. The initial count register is written through cfg_valid /
// cfg_ready while idle; it reloads the count only when no one is waiting.
// No clearing pass follows reset: the block is ready as soon as reset
// is released.
module priority_semaphore_queue_top import psq_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  // request channel
  input  logic             start,
  output logic             busy,
  input  req_t             in_req,
  // result channel
  output logic             out_valid,
  output rsp_t             out_rsp,
  // configuration
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  cmd_t cmd;

  // Sequence capture, execute and result strobe.
  psq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .cfg_valid (cfg_valid),
    .busy      (busy),
    .cfg_ready (cfg_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // Hold the count, the sorted queue and the result register.
  psq_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_req   (in_req),
    .cfg_data (cfg_data),
    .out_rsp  (out_rsp)
  );

endmodule
